@@ rtl/core/fud_pkg.sv @@
// Shared types and constants of the fisheye undistortion map generator.
// Holds the CORDIC arctangent table, fixed-point constants and register codes.
// Has no dependencies; the top level, fud_rot, fud_vec and the testbench refer to it.
package fud_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 34;
    localparam int VEC_W        = 48;
    localparam int FRAC_W       = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] HALF_PI     = 34'sd1686629713;

    localparam logic [31:0] RST_FOCAL    = 32'd16777216;
    localparam logic [31:0] RST_CENTER_X = 32'd20971520;
    localparam logic [31:0] RST_CENTER_Y = 32'd15728640;
    localparam logic [15:0] RST_ZOOM     = 16'd4915;
    localparam logic [31:0] RST_LENS     = 32'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X     = 3'd0,
        REG_FOCAL_Y     = 3'd1,
        REG_IN_CENTER_X = 3'd2,
        REG_IN_CENTER_Y = 3'd3,
        REG_OUT_CENTER_X = 3'd4,
        REG_OUT_CENTER_Y = 3'd5,
        REG_ZOOM_SCALE  = 3'd6,
        REG_LENS_DIST   = 3'd7
    } cfg_reg_t;

    // Arctangent of 2^-i in Q4.30 radians (34-bit signed).
    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        case (i)
            0:  return 34'sd843314857;
            1:  return 34'sd497837829;
            2:  return 34'sd263043836;
            3:  return 34'sd133525158;
            4:  return 34'sd67021686;
            5:  return 34'sd33543515;
            6:  return 34'sd16775850;
            7:  return 34'sd8388437;
            8:  return 34'sd4194282;
            9:  return 34'sd2097149;
            10: return 34'sd1048575;
            11: return 34'sd524287;
            12: return 34'sd262143;
            13: return 34'sd131071;
            14: return 34'sd65535;
            15: return 34'sd32767;
            16: return 34'sd16383;
            17: return 34'sd8191;
            18: return 34'sd4095;
            19: return 34'sd2047;
            20: return 34'sd1023;
            21: return 34'sd511;
            22: return 34'sd255;
            23: return 34'sd128;
            24: return 34'sd64;
            25: return 34'sd32;
            26: return 34'sd16;
            27: return 34'sd8;
            28: return 34'sd4;
            29: return 34'sd2;
            default: return '0;
        endcase
    endfunction

endpackage

@@ rtl/core/fisheye_undistort_map_generator.sv @@
// Top level of the fisheye undistortion map generator.
// Depends on fud_pkg, fud_div, fud_sqrt, fud_rot and fud_vec.
//
// For each output pixel item (s_out_col, s_out_row) the block returns one item
// with the source position in the distorted fisheye image under the
// field-of-view lens model: a saturated integer column and row and a fraction
// index for the interpolation table.
// Both channels use valid/ready; an item moves when valid and ready are high
// at a rising edge of aclk. Configuration is a plain write port: cfg_wr_en,
// cfg_index and cfg_wdata, with no wait state. Registers must be written by
// the user only while no item is in flight; the block does not enforce it.
// Throughput is one item per clock while m_ready does not stall the output.
// Items pass through a chain of 178 register stages: the normalising divider
// (32 stages), the square root (33), the vectoring CORDIC (31), the angle
// divider (42) and the direction divider (32), plus eight single stages.
// The whole pipeline advances together. When the result register is full and
// m_ready is low, every stage holds and s_ready drops; nothing is lost or
// repeated. Synchronous reset on aresetn empties the pipeline and restores
// the register defaults. The half-angle sine and cosine come from a separate
// free-running CORDIC that settles after a change of the lens register, well
// before any item reaches the stage that uses them.
module fisheye_undistort_map_generator #(
    parameter int MAX_COLS      = 2048,
    parameter int SUBPIXEL_BITS = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [fud_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fud_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [10:0]                       s_out_col,
    input  logic [10:0]                       s_out_row,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [15:0]                m_src_x_int,
    output logic signed [15:0]                m_src_y_int,
    output logic [fud_pkg::FRAC_W-1:0]        m_frac_index
);

    localparam int SB  = SUBPIXEL_BITS;
    localparam int SH  = 36 - SB;
    localparam int FW  = 2 * SB;
    localparam logic signed [66:0] ROUND_ADD = 67'sd1 <<< (SH - 1);
    localparam logic signed [66:0] I_MAX = (67'sd1 <<< (15 + SB)) - 67'sd1;
    localparam logic signed [66:0] I_MIN = -(67'sd1 <<< (15 + SB));
    localparam logic [30:0]        NORM_MAX = 31'h7FFF_FFFF;
    localparam logic signed [42:0] T_MAX = 43'sd1073741823;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [31:0] focal_x_reg, focal_y_reg;
    logic [31:0] in_center_x_reg, in_center_y_reg;
    logic [31:0] out_center_x_reg, out_center_y_reg;
    logic [15:0] zoom_scale_reg;
    logic [31:0] lens_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg      <= fud_pkg::RST_FOCAL;
            focal_y_reg      <= fud_pkg::RST_FOCAL;
            in_center_x_reg  <= fud_pkg::RST_CENTER_X;
            in_center_y_reg  <= fud_pkg::RST_CENTER_Y;
            out_center_x_reg <= fud_pkg::RST_CENTER_X;
            out_center_y_reg <= fud_pkg::RST_CENTER_Y;
            zoom_scale_reg   <= fud_pkg::RST_ZOOM;
            lens_reg         <= fud_pkg::RST_LENS;
        end else if (cfg_wr_en) begin
            unique case (fud_pkg::cfg_reg_t'(cfg_index))
                fud_pkg::REG_FOCAL_X:      focal_x_reg      <= cfg_wdata;
                fud_pkg::REG_FOCAL_Y:      focal_y_reg      <= cfg_wdata;
                fud_pkg::REG_IN_CENTER_X:  in_center_x_reg  <= cfg_wdata;
                fud_pkg::REG_IN_CENTER_Y:  in_center_y_reg  <= cfg_wdata;
                fud_pkg::REG_OUT_CENTER_X: out_center_x_reg <= cfg_wdata;
                fud_pkg::REG_OUT_CENTER_Y: out_center_y_reg <= cfg_wdata;
                fud_pkg::REG_ZOOM_SCALE:   zoom_scale_reg   <= cfg_wdata[15:0];
                fud_pkg::REG_LENS_DIST:    lens_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero focal length acts as one LSB, both as divisor and as factor.
    logic [31:0] fx_eff, fy_eff;
    assign fx_eff = (focal_x_reg == '0) ? 32'd1 : focal_x_reg;
    assign fy_eff = (focal_y_reg == '0) ? 32'd1 : focal_y_reg;

    // The whole pipeline moves when the result register can take a new item.
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ------------------------------------------------------------------
    // Stage 0: clamp the pixel index, centre it and apply the zoom.
    // ------------------------------------------------------------------
    logic [10:0]        col_c, row_c;
    logic signed [33:0] dx, dy;
    logic signed [50:0] xs_x_next, xs_y_next;
    logic signed [50:0] xs_x_reg, xs_y_reg;
    logic               s0_vld_reg;

    assign col_c = (int'(s_out_col) > MAX_COLS - 1) ? 11'(MAX_COLS - 1) : s_out_col;
    assign row_c = (int'(s_out_row) > MAX_COLS - 1) ? 11'(MAX_COLS - 1) : s_out_row;
    assign dx = $signed({7'b0, col_c, 16'b0}) - $signed({2'b0, out_center_x_reg});
    assign dy = $signed({7'b0, row_c, 16'b0}) - $signed({2'b0, out_center_y_reg});
    assign xs_x_next = dx * $signed({1'b0, zoom_scale_reg});
    assign xs_y_next = dy * $signed({1'b0, zoom_scale_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xs_x_reg <= xs_x_next;
            xs_y_reg <= xs_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Normalising division by the focal lengths. A quotient of 2^31 or more
    // is caught up front and saturates.
    // ------------------------------------------------------------------
    logic [50:0] ax_full, ay_full;
    logic [57:0] nmag_x, nmag_y;
    logic        nsat_x, nsat_y;
    logic        n_vld;
    logic [30:0] nq_x, nq_y;
    logic [1:0]  nside_x, nside_y;

    assign ax_full = xs_x_reg[50] ? 51'(-xs_x_reg) : 51'(xs_x_reg);
    assign ay_full = xs_y_reg[50] ? 51'(-xs_y_reg) : 51'(xs_y_reg);
    assign nmag_x  = {ax_full[49:0], 8'b0};
    assign nmag_y  = {ay_full[49:0], 8'b0};
    assign nsat_x  = {5'b0, nmag_x[57:31]} >= fx_eff;
    assign nsat_y  = {5'b0, nmag_y[57:31]} >= fy_eff;

    fud_div #(.QW(31), .DW(32), .SIDE_W(2)) u_div_nx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s0_vld_reg),
        .rem_i(nsat_x ? 32'd0 : {5'b0, nmag_x[57:31]}),
        .num_i(nmag_x[30:0]), .den_i(fx_eff),
        .side_i({xs_x_reg[50], nsat_x}),
        .valid_o(n_vld), .quo_o(nq_x), .side_o(nside_x)
    );

    fud_div #(.QW(31), .DW(32), .SIDE_W(2)) u_div_ny (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s0_vld_reg),
        .rem_i(nsat_y ? 32'd0 : {5'b0, nmag_y[57:31]}),
        .num_i(nmag_y[30:0]), .den_i(fy_eff),
        .side_i({xs_y_reg[50], nsat_y}),
        .valid_o(), .quo_o(nq_y), .side_o(nside_y)
    );

    // ------------------------------------------------------------------
    // Stage 2: signed normalised coordinates. Stage 3: their squares.
    // ------------------------------------------------------------------
    logic [30:0]        nx_mag, ny_mag;
    logic signed [31:0] x_next, y_next;
    logic signed [31:0] x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [63:0] xx_next, yy_next;
    logic [63:0]        xx_reg, yy_reg;
    logic               s2_vld_reg, s3_vld_reg;

    assign nx_mag = nside_x[0] ? NORM_MAX : nq_x;
    assign ny_mag = nside_y[0] ? NORM_MAX : nq_y;
    assign x_next = nside_x[1] ? -$signed({1'b0, nx_mag}) : $signed({1'b0, nx_mag});
    assign y_next = nside_y[1] ? -$signed({1'b0, ny_mag}) : $signed({1'b0, ny_mag});
    assign xx_next = x2_reg * x2_reg;
    assign yy_next = y2_reg * y2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= n_vld;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg <= x_next;
            y2_reg <= y_next;
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
            xx_reg <= xx_next;
            yy_reg <= yy_next;
        end
    end

    // ------------------------------------------------------------------
    // Radius as the floor of the square root of the summed squares.
    // ------------------------------------------------------------------
    logic        r_vld;
    logic [31:0] r_root;
    logic [63:0] r_side;

    fud_sqrt #(.SIDE_W(64)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s3_vld_reg),
        .val_i(xx_reg + yy_reg), .side_i({x3_reg, y3_reg}),
        .valid_o(r_vld), .root_o(r_root), .side_o(r_side)
    );

    // Half-angle sine and cosine of the lens distortion.
    logic signed [fud_pkg::ANG_W-1:0] half_cos, half_sin;

    fud_rot u_rot (
        .aclk(aclk), .lens_distortion(lens_reg),
        .cos_o(half_cos), .sin_o(half_sin)
    );

    // ------------------------------------------------------------------
    // Stage 4: r times sin(D/2), which scaled gives 2 r sin(D/2).
    // ------------------------------------------------------------------
    logic signed [66:0] rs_next, rs_reg;
    logic [95:0]        s4_side_reg;
    logic               s4_vld_reg;

    assign rs_next = $signed({1'b0, r_root}) * half_sin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s4_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_reg      <= rs_next;
            s4_side_reg <= {r_side, r_root};
        end
    end

    // The vector (|c|, sign(c) * 2 r s) has the angle atan(2 r tan(D/2)).
    logic signed [fud_pkg::VEC_W-1:0] vy_raw, vx_in, vy_in;
    logic signed [fud_pkg::VEC_W-1:0] cos_ext;

    assign vy_raw  = rs_reg[66:19];
    assign cos_ext = fud_pkg::VEC_W'(half_cos);
    assign vx_in   = half_cos[fud_pkg::ANG_W-1] ? -cos_ext : cos_ext;
    assign vy_in   = half_cos[fud_pkg::ANG_W-1] ? -vy_raw : vy_raw;

    logic                             a_vld;
    logic signed [fud_pkg::ANG_W-1:0] a_ang;
    logic [95:0]                      a_side;

    fud_vec #(.SIDE_W(96)) u_vec (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s4_vld_reg),
        .x_i(vx_in), .y_i(vy_in), .side_i(s4_side_reg),
        .valid_o(a_vld), .ang_o(a_ang), .side_o(a_side)
    );

    // ------------------------------------------------------------------
    // Angle divided by D in Q.30. Quotients of 2^41 or more saturate the
    // angle scale either way, so they are flagged before the divider.
    // ------------------------------------------------------------------
    logic [32:0]  ang_mag;
    logic         ang_neg, ang_sat;
    logic         q_vld;
    logic [40:0]  q_ang;
    logic [97:0]  q_side;

    assign ang_neg = a_ang[fud_pkg::ANG_W-1];
    assign ang_mag = ang_neg ? 33'(-a_ang) : 33'(a_ang);
    assign ang_sat = {10'b0, ang_mag[32:11]} >= lens_reg;

    fud_div #(.QW(41), .DW(32), .SIDE_W(98)) u_div_ang (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(a_vld),
        .rem_i(ang_sat ? 32'd0 : {10'b0, ang_mag[32:11]}),
        .num_i({ang_mag[10:0], 30'b0}), .den_i(lens_reg),
        .side_i({a_side, ang_neg, ang_sat}),
        .valid_o(q_vld), .quo_o(q_ang), .side_o(q_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: the radial scale t in Q.20, saturated to 1024 normalised.
    // ------------------------------------------------------------------
    logic signed [31:0] q_x, q_y;
    logic [31:0]        q_r;
    logic signed [42:0] q_signed, q_shift;
    logic signed [30:0] t_next;
    logic signed [30:0] t_reg;
    logic signed [31:0] x5_reg, y5_reg;
    logic [31:0]        r5_reg;
    logic               s5_vld_reg;

    assign q_x = $signed(q_side[97:66]);
    assign q_y = $signed(q_side[65:34]);
    assign q_r = q_side[33:2];
    assign q_signed = q_side[1] ? -$signed({2'b0, q_ang}) : $signed({2'b0, q_ang});
    assign q_shift  = q_signed >>> 10;

    always_comb begin
        if (q_r == '0) begin
            t_next = '0;
        end else if (lens_reg == '0) begin
            // Without distortion the scale is plain r.
            t_next = (q_r > 32'd1073741823) ? 31'(T_MAX) : 31'(q_r);
        end else if (q_side[0]) begin
            t_next = q_side[1] ? 31'(-T_MAX) : 31'(T_MAX);
        end else if (q_shift > T_MAX) begin
            t_next = 31'(T_MAX);
        end else if (q_shift < -T_MAX) begin
            t_next = 31'(-T_MAX);
        end else begin
            t_next = q_shift[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg  <= t_next;
            x5_reg <= q_x;
            y5_reg <= q_y;
            r5_reg <= q_r;
        end
    end

    // ------------------------------------------------------------------
    // Direction cosines X/r and Y/r in Q.30. Their magnitude never exceeds
    // one, so no saturation check is needed. A zero radius gives t of zero,
    // which makes whatever the divider returns irrelevant.
    // ------------------------------------------------------------------
    logic [31:0] cx_abs, cy_abs;
    logic        c_vld;
    logic [30:0] cq_x, cq_y;
    logic [31:0] c_side_x;
    logic        c_side_y;

    assign cx_abs = x5_reg[31] ? 32'(-x5_reg) : 32'(x5_reg);
    assign cy_abs = y5_reg[31] ? 32'(-y5_reg) : 32'(y5_reg);

    fud_div #(.QW(31), .DW(32), .SIDE_W(32)) u_div_cx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s5_vld_reg),
        .rem_i({2'b0, cx_abs[30:1]}), .num_i({cx_abs[0], 30'b0}), .den_i(r5_reg),
        .side_i({t_reg, x5_reg[31]}),
        .valid_o(c_vld), .quo_o(cq_x), .side_o(c_side_x)
    );

    fud_div #(.QW(31), .DW(32), .SIDE_W(1)) u_div_cy (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s5_vld_reg),
        .rem_i({2'b0, cy_abs[30:1]}), .num_i({cy_abs[0], 30'b0}), .den_i(r5_reg),
        .side_i(y5_reg[31]),
        .valid_o(), .quo_o(cq_y), .side_o(c_side_y)
    );

    // ------------------------------------------------------------------
    // Stage 6: normalised offset w = t * cos in Q.20.
    // Stage 7: offset in pixels, focal * w in Q.36.
    // ------------------------------------------------------------------
    logic signed [30:0] t6;
    logic signed [31:0] cos_x, cos_y;
    logic signed [62:0] wp_x, wp_y;
    logic signed [32:0] w_x_reg, w_y_reg;
    logic signed [65:0] f_x_next, f_y_next;
    logic signed [65:0] f_x_reg, f_y_reg;
    logic               s6_vld_reg, s7_vld_reg;

    assign t6    = $signed(c_side_x[31:1]);
    assign cos_x = c_side_x[0] ? -$signed({1'b0, cq_x}) : $signed({1'b0, cq_x});
    assign cos_y = c_side_y ? -$signed({1'b0, cq_y}) : $signed({1'b0, cq_y});
    assign wp_x  = t6 * cos_x;
    assign wp_y  = t6 * cos_y;
    assign f_x_next = $signed({1'b0, fx_eff}) * w_x_reg;
    assign f_y_next = $signed({1'b0, fy_eff}) * w_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else if (en) begin
            s6_vld_reg <= c_vld;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_x_reg <= wp_x[62:30];
            w_y_reg <= wp_y[62:30];
            f_x_reg <= f_x_next;
            f_y_reg <= f_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: add the principal point, round half up to the subpixel grid,
    // saturate and split into integer part and fraction.
    // ------------------------------------------------------------------
    logic signed [66:0] pos_x, pos_y, i_x, i_y, is_x, is_y;
    logic [FW-1:0]      frac_cat;
    logic [FW+fud_pkg::FRAC_W-1:0] frac_ext;

    assign pos_x = $signed({15'b0, in_center_x_reg, 20'b0}) + $signed({f_x_reg[65], f_x_reg});
    assign pos_y = $signed({15'b0, in_center_y_reg, 20'b0}) + $signed({f_y_reg[65], f_y_reg});
    assign i_x   = (pos_x + ROUND_ADD) >>> SH;
    assign i_y   = (pos_y + ROUND_ADD) >>> SH;
    assign is_x  = (i_x > I_MAX) ? I_MAX : ((i_x < I_MIN) ? I_MIN : i_x);
    assign is_y  = (i_y > I_MAX) ? I_MAX : ((i_y < I_MIN) ? I_MIN : i_y);
    assign frac_cat = {is_y[SB-1:0], is_x[SB-1:0]};
    assign frac_ext = {{fud_pkg::FRAC_W{1'b0}}, frac_cat};

    logic signed [15:0]         src_x_reg, src_y_reg;
    logic [fud_pkg::FRAC_W-1:0] frac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            src_x_reg <= is_x[SB+15:SB];
            src_y_reg <= is_y[SB+15:SB];
            frac_reg  <= frac_ext[fud_pkg::FRAC_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_src_x_int  = src_x_reg;
    assign m_src_y_int  = src_y_reg;
    assign m_frac_index = frac_reg;

endmodule

@@ rtl/core/fud_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// The caller supplies the upper dividend part already below the divisor.
// Depends on nothing else in the block.
module fud_div #(
    parameter int QW     = 31,
    parameter int DW     = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_i,
    input  logic [DW-1:0]     rem_i,
    input  logic [QW-1:0]     num_i,
    input  logic [DW-1:0]     den_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output logic [QW-1:0]     quo_o,
    output logic [SIDE_W-1:0] side_o
);

    logic              vld_reg  [QW+1];
    logic [DW-1:0]     rem_reg  [QW+1];
    logic [QW-1:0]     nq_reg   [QW+1];
    logic [DW-1:0]     den_reg  [QW+1];
    logic [SIDE_W-1:0] side_reg [QW+1];

    logic [DW:0]       part     [QW];
    logic              ge       [QW];
    logic [DW-1:0]     rem_next [QW];
    logic [QW-1:0]     nq_next  [QW];

    // Each stage shifts in the next dividend bit and subtracts when it can.
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            part[k]     = {rem_reg[k], nq_reg[k][QW-1]};
            ge[k]       = part[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge[k] ? DW'(part[k] - {1'b0, den_reg[k]}) : part[k][DW-1:0];
            nq_next[k]  = {nq_reg[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= valid_i;
            for (int k = 0; k < QW; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem_i;
            nq_reg[0]   <= num_i;
            den_reg[0]  <= den_i;
            side_reg[0] <= side_i;
            for (int k = 0; k < QW; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                nq_reg[k+1]   <= nq_next[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign valid_o = vld_reg[QW];
    assign quo_o   = nq_reg[QW];
    assign side_o  = side_reg[QW];

endmodule

@@ rtl/core/fud_sqrt.sv @@
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Gives the floor of the square root; depends on nothing else in the block.
module fud_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_i,
    input  logic [63:0]       val_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output logic [31:0]       root_o,
    output logic [SIDE_W-1:0] side_o
);

    localparam int STAGES = 32;

    logic              vld_reg  [STAGES+1];
    logic [33:0]       rem_reg  [STAGES+1];
    logic [31:0]       root_reg [STAGES+1];
    logic [63:0]       val_reg  [STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];

    logic [35:0]       part      [STAGES];
    logic [35:0]       trial     [STAGES];
    logic              ge        [STAGES];
    logic [33:0]       rem_next  [STAGES];
    logic [31:0]       root_next [STAGES];

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            part[k]      = {rem_reg[k], val_reg[k][63:62]};
            trial[k]     = {2'b00, root_reg[k], 2'b01};
            ge[k]        = part[k] >= trial[k];
            rem_next[k]  = ge[k] ? 34'(part[k] - trial[k]) : part[k][33:0];
            root_next[k] = {root_reg[k][30:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= STAGES; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= valid_i;
            for (int k = 0; k < STAGES; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            val_reg[0]  <= val_i;
            side_reg[0] <= side_i;
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                val_reg[k+1]  <= {val_reg[k][61:0], 2'b00};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign valid_o = vld_reg[STAGES];
    assign root_o  = root_reg[STAGES];
    assign side_o  = side_reg[STAGES];

endmodule

@@ rtl/core/fud_rot.sv @@
// Free-running rotation CORDIC giving cosine and sine of half the lens angle.
// Uses the arctangent table and gain constant of fud_pkg.
module fud_rot (
    input  logic                              aclk,
    input  logic [31:0]                       lens_distortion,
    output logic signed [fud_pkg::ANG_W-1:0]  cos_o,
    output logic signed [fud_pkg::ANG_W-1:0]  sin_o
);

    localparam int N = fud_pkg::CORDIC_STEPS;

    logic signed [fud_pkg::ANG_W-1:0] x_reg [N+1];
    logic signed [fud_pkg::ANG_W-1:0] y_reg [N+1];
    logic signed [fud_pkg::ANG_W-1:0] z_reg [N+1];
    logic signed [fud_pkg::ANG_W-1:0] z_start;

    assign z_start = $signed({3'b000, lens_distortion[31:1]});

    // The user must see that the input changes only while the block is idle
    // (unchecked here), so the output settles long before any item reads it.
    always_ff @(posedge aclk) begin
        if (z_start > fud_pkg::HALF_PI) begin
            x_reg[0] <= '0;
            y_reg[0] <= fud_pkg::CORDIC_GAIN;
            z_reg[0] <= z_start - fud_pkg::HALF_PI;
        end else begin
            x_reg[0] <= fud_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z_start;
        end
        for (int k = 0; k < N; k++) begin
            if (z_reg[k] >= 0) begin
                x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] - fud_pkg::atan_q30(k);
            end else begin
                x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                z_reg[k+1] <= z_reg[k] + fud_pkg::atan_q30(k);
            end
        end
    end

    assign cos_o = x_reg[N];
    assign sin_o = y_reg[N];

endmodule

@@ rtl/core/fud_vec.sv @@
// Pipelined vectoring CORDIC giving the angle of a vector, one step per stage.
// Uses the arctangent table of fud_pkg. A vector with zero y gives angle zero.
module fud_vec #(
    parameter int SIDE_W = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              valid_i,
    input  logic signed [fud_pkg::VEC_W-1:0]  x_i,
    input  logic signed [fud_pkg::VEC_W-1:0]  y_i,
    input  logic [SIDE_W-1:0]                 side_i,
    output logic                              valid_o,
    output logic signed [fud_pkg::ANG_W-1:0]  ang_o,
    output logic [SIDE_W-1:0]                 side_o
);

    localparam int N = fud_pkg::CORDIC_STEPS;

    logic                             vld_reg  [N+1];
    logic                             zero_reg [N+1];
    logic signed [fud_pkg::VEC_W-1:0] x_reg    [N+1];
    logic signed [fud_pkg::VEC_W-1:0] y_reg    [N+1];
    logic signed [fud_pkg::ANG_W-1:0] z_reg    [N+1];
    logic [SIDE_W-1:0]                side_reg [N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= valid_i;
            for (int k = 0; k < N; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_i;
            y_reg[0]    <= y_i;
            z_reg[0]    <= '0;
            zero_reg[0] <= (y_i == '0);
            side_reg[0] <= side_i;
            for (int k = 0; k < N; k++) begin
                // A y of exactly zero takes the second direction.
                if (y_reg[k] > 0) begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + fud_pkg::atan_q30(k);
                end else begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - fud_pkg::atan_q30(k);
                end
                zero_reg[k+1] <= zero_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign valid_o = vld_reg[N];
    assign ang_o   = zero_reg[N] ? '0 : z_reg[N];
    assign side_o  = side_reg[N];

endmodule

@@ sim/fisheye_undistort_map_generator_test.sv @@
// Self-checking testbench for the fisheye undistortion map generator.
// Depends on fud_pkg and the fisheye_undistort_map_generator top level only.
// A built-in fixed-point predictor computes the expected source position of every item.
module fisheye_undistort_map_generator_test;

    // The parameters of the block under test; the predictor follows the same values.
    localparam int MAX_COL_IDX = 2047;
    localparam int SUB_BITS    = 5;
    localparam int ROT_STEPS   = 30;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint HALFPI_Q30  = 64'sd1686629713;
    localparam longint NORM_LIMIT  = 64'sd2147483647;
    localparam longint THETA_LIMIT = 64'sd1073741823;
    localparam int DRAIN_CYCLES = 200;

    // One result item: saturated source column and row plus interpolation index.
    typedef struct packed {
        logic signed [15:0]         src_x;
        logic signed [15:0]         src_y;
        logic [fud_pkg::FRAC_W-1:0] frac;
    } src_coord_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [fud_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fud_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [10:0] s_out_col;
    logic [10:0] s_out_row;
    logic m_valid;
    logic m_ready;
    logic signed [15:0] m_src_x_int;
    logic signed [15:0] m_src_y_int;
    logic [fud_pkg::FRAC_W-1:0] m_frac_index;

    // Shadow copy of the block's registers, kept in step with every write.
    logic [31:0] lens_focal_x, lens_focal_y;
    logic [31:0] src_center_x, src_center_y;
    logic [31:0] dst_center_x, dst_center_y;
    logic [15:0] zoom_q12;
    logic [31:0] fov_angle;

    src_coord_t expected_coords[$];
    int mismatches;
    int results_seen;
    int items_sent;
    int burst_left;
    bit gaps_off;
    int hold_off_cycles;
    int ready_mode;

    longint arctan_q30[ROT_STEPS] = '{
        843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 128, 64, 32,
        16, 8, 4, 2};

    fisheye_undistort_map_generator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_out_col    (s_out_col),
        .s_out_row    (s_out_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_src_x_int  (m_src_x_int),
        .m_src_y_int  (m_src_y_int),
        .m_frac_index (m_frac_index)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // A zero focal length is treated as one LSB, both as divisor and as factor.
    function automatic longint focal_or_lsb(logic [31:0] f);
        return (f == 0) ? 64'sd1 : longint'(f);
    endfunction

    function automatic longint clamp_symmetric(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Centred, zoomed and focal-normalised coordinate in Q.20.
    function automatic longint norm_coord(logic [10:0] idx, logic [31:0] centre,
                                          logic [31:0] focal);
        longint offset;
        longint zoomed;
        offset = (longint'(idx) <<< 16) - longint'(centre);
        zoomed = offset * longint'(zoom_q12);
        return clamp_symmetric((zoomed * 256) / focal_or_lsb(focal), NORM_LIMIT);
    endfunction

    function automatic longint radius_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Map a normalised direction back to a rounded, saturated 1/32-pixel position.
    function automatic longint subpixel_pos(logic [31:0] centre, logic [31:0] focal,
                                            longint t, longint dir);
        longint w;
        longint pos;
        longint idx;
        longint lim;
        lim = 64'sd1 <<< (15 + SUB_BITS);
        w = (t * dir) >>> 30;
        pos = (longint'(centre) <<< 20) + focal_or_lsb(focal) * w;
        idx = (pos + (64'sd1 <<< (35 - SUB_BITS))) >>> (36 - SUB_BITS);
        if (idx > lim - 1) idx = lim - 1;
        if (idx < -lim) idx = -lim;
        return idx;
    endfunction

    function automatic src_coord_t predict_source(logic [10:0] col, logic [10:0] row);
        longint nx, ny, rad, t, dir_x, dir_y, hx, hy, hz, vx, vy, vz, sx, sy, iu, iv;
        src_coord_t res;
        t = 0;
        dir_x = 0;
        dir_y = 0;
        if (col > MAX_COL_IDX) col = MAX_COL_IDX;
        if (row > MAX_COL_IDX) row = MAX_COL_IDX;
        nx = norm_coord(col, dst_center_x, lens_focal_x);
        ny = norm_coord(row, dst_center_y, lens_focal_y);
        rad = radius_sqrt(longint'(nx * nx) + longint'(ny * ny));
        if (rad != 0) begin
            dir_x = (nx * 64'sd1073741824) / rad;
            dir_y = (ny * 64'sd1073741824) / rad;
            if (fov_angle == 0) begin
                t = rad;
            end else begin
                // Rotation CORDIC for cosine and sine of half the lens angle.
                hz = longint'(fov_angle >> 1);
                if (hz > HALFPI_Q30) begin
                    hx = 0;
                    hy = GAIN_Q30;
                    hz -= HALFPI_Q30;
                end else begin
                    hx = GAIN_Q30;
                    hy = 0;
                end
                for (int i = 0; i < ROT_STEPS; i++) begin
                    sx = hx >>> i;
                    sy = hy >>> i;
                    if (hz >= 0) begin
                        hx -= sy; hy += sx; hz -= arctan_q30[i];
                    end else begin
                        hx += sy; hy -= sx; hz += arctan_q30[i];
                    end
                end
                // Vectoring CORDIC for atan(2 r tan(D/2)); a vector with zero y gives zero.
                vy = (rad * hy) >>> 19;
                vx = hx;
                if (hx < 0) begin
                    vx = -hx;
                    vy = -vy;
                end
                vz = 0;
                if (vy != 0) begin
                    for (int i = 0; i < ROT_STEPS; i++) begin
                        sx = vx >>> i;
                        sy = vy >>> i;
                        if (vy > 0) begin
                            vx += sy; vy -= sx; vz += arctan_q30[i];
                        end else begin
                            vx -= sy; vy += sx; vz -= arctan_q30[i];
                        end
                    end
                end
                t = ((vz * 64'sd1073741824) / longint'(fov_angle)) >>> 10;
            end
            t = clamp_symmetric(t, THETA_LIMIT);
        end
        iu = subpixel_pos(src_center_x, lens_focal_x, t, dir_x);
        iv = subpixel_pos(src_center_y, lens_focal_y, t, dir_y);
        res.src_x = 16'(iu >>> SUB_BITS);
        res.src_y = 16'(iv >>> SUB_BITS);
        res.frac = fud_pkg::FRAC_W'(((iv & 31) << SUB_BITS) | (iu & 31));
        return res;
    endfunction

    // Receiver: a changing stall pattern, with long hold-offs on request.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            if ($urandom_range(0, 99) == 0) ready_mode <= $urandom_range(0, 2);
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Every accepted result item is compared with the oldest expectation.
    always @(posedge aclk) begin
        src_coord_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_coords.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: x=%0d y=%0d frac=%0d",
                             m_src_x_int, m_src_y_int, m_frac_index);
            end else begin
                want = expected_coords.pop_front();
                if (m_src_x_int !== want.src_x || m_src_y_int !== want.src_y ||
                    m_frac_index !== want.frac) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected x=%0d y=%0d frac=%0d, got %0d %0d %0d",
                                 want.src_x, want.src_y, want.frac,
                                 m_src_x_int, m_src_y_int, m_frac_index);
                end
            end
        end
    end

    // Writes one register; the write enable stays high until the caller drops it
    // after its last write, so back-to-back writes need no idle cycle.
    task automatic write_reg(fud_pkg::cfg_reg_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            fud_pkg::REG_FOCAL_X:      lens_focal_x = value;
            fud_pkg::REG_FOCAL_Y:      lens_focal_y = value;
            fud_pkg::REG_IN_CENTER_X:  src_center_x = value;
            fud_pkg::REG_IN_CENTER_Y:  src_center_y = value;
            fud_pkg::REG_OUT_CENTER_X: dst_center_x = value;
            fud_pkg::REG_OUT_CENTER_Y: dst_center_y = value;
            fud_pkg::REG_ZOOM_SCALE:   zoom_q12 = value[15:0];
            fud_pkg::REG_LENS_DIST:    fov_angle = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] icx,
                             logic [31:0] icy, logic [31:0] ocx, logic [31:0] ocy,
                             logic [15:0] zoom, logic [31:0] lens);
        write_reg(fud_pkg::REG_FOCAL_X, fx);
        write_reg(fud_pkg::REG_FOCAL_Y, fy);
        write_reg(fud_pkg::REG_IN_CENTER_X, icx);
        write_reg(fud_pkg::REG_IN_CENTER_Y, icy);
        write_reg(fud_pkg::REG_OUT_CENTER_X, ocx);
        write_reg(fud_pkg::REG_OUT_CENTER_Y, ocy);
        write_reg(fud_pkg::REG_ZOOM_SCALE, {16'd0, zoom});
        write_reg(fud_pkg::REG_LENS_DIST, lens);
        cfg_wr_en <= 1'b0;
        // Give the half-angle CORDIC of the block time to settle.
        repeat (40) @(posedge aclk);
    endtask

    // Offers one pixel item and waits for its handshake; a gap may come first.
    task automatic send_pixel(logic [10:0] col, logic [10:0] row);
        if (!gaps_off && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_out_col <= col;
        s_out_row <= row;
        do @(posedge aclk); while (!s_ready);
        expected_coords.push_back(predict_source(col, row));
        items_sent++;
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_coords.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [10:0] pick_index();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd2047;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic test_default_extremes;
        send_pixel(11'd320, 11'd240);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd1365, 11'd682);
        send_pixel(11'd321, 11'd240);
        send_pixel(11'd320, 11'd239);
        drain();
    endtask

    task automatic test_special_settings;
        // Zero lens distortion: the scale falls back to plain r.
        write_reg(fud_pkg::REG_LENS_DIST, 32'd0);
        cfg_wr_en <= 1'b0;
        repeat (40) @(posedge aclk);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd700, 11'd100);
        drain();
        // Zero focal lengths and the largest zoom drive the normalised coordinates into their clamp.
        write_all(32'd0, 32'd0, fud_pkg::RST_CENTER_X, fud_pkg::RST_CENTER_Y, 32'd0, 32'd0,
                  16'hFFFF, 32'd3373259426);
        send_pixel(11'd2047, 11'd5);
        send_pixel(11'd0, 11'd0);
        send_pixel(11'd2047, 11'd2047);
        drain();
        // Zero zoom maps every pixel onto the source principal point.
        write_all(32'd65536, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 16'd0, 32'd1);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd9, 11'd1000);
        drain();
        // Extreme principal point and a small focal length saturate the source.
        write_all(32'd65536, 32'd65536, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
                  32'hFFFFFFFF, 16'd1, 32'd1);
        send_pixel(11'd2047, 11'd0);
        send_pixel(11'd0, 11'd2047);
        send_pixel(11'd1024, 11'd1024);
        drain();
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0,
                  16'hFFFF, 32'd3373259426);
        send_pixel(11'd2047, 11'd2047);
        send_pixel(11'd0, 11'd0);
        drain();
    endtask

    task automatic random_settings;
        logic [31:0] fx;
        logic [31:0] fy;
        if ($urandom_range(0, 3) == 0) begin
            fx = $urandom_range(32'd65536, 32'hFFFFFFFF);
            fy = $urandom_range(32'd65536, 32'hFFFFFFFF);
        end else begin
            fx = $urandom_range(32'd65536 * 50, 32'd65536 * 2000);
            fy = $urandom_range(32'd65536 * 50, 32'd65536 * 2000);
        end
        write_all(fx, fy, $urandom_range(0, 32'd65536 * 2048),
                  ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'd65536 * 2048),
                  $urandom_range(0, 32'd65536 * 2048),
                  ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 32'd65536 * 2048),
                  16'($urandom_range(1, 16'hFFFF)),
                  $urandom_range(1, 32'd3373259426));
    endtask

    task automatic test_random_phases;
        for (int phase = 0; phase < 10; phase++) begin
            random_settings();
            gaps_off = (phase % 3 == 2);
            for (int n = 0; n < 100; n++) begin
                send_pixel(pick_index(), pick_index());
                if (phase == 4 && n == 50) drain();
            end
            gaps_off = 1'b0;
            drain();
        end
    endtask

    task automatic test_output_stall;
        // The receiver holds off long enough for the pipeline to fill and refuse items.
        random_settings();
        gaps_off = 1'b1;
        hold_off_cycles = 400;
        for (int n = 0; n < 250; n++) send_pixel(pick_index(), pick_index());
        gaps_off = 1'b0;
        drain();
    endtask

    initial begin
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        burst_left = 0;
        gaps_off = 1'b0;
        hold_off_cycles = 0;
        ready_mode = 0;
        lens_focal_x = fud_pkg::RST_FOCAL;
        lens_focal_y = fud_pkg::RST_FOCAL;
        src_center_x = fud_pkg::RST_CENTER_X;
        src_center_y = fud_pkg::RST_CENTER_Y;
        dst_center_x = fud_pkg::RST_CENTER_X;
        dst_center_y = fud_pkg::RST_CENTER_Y;
        zoom_q12 = fud_pkg::RST_ZOOM;
        fov_angle = fud_pkg::RST_LENS;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= fud_pkg::REG_FOCAL_X;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_out_col <= '0;
        s_out_row <= '0;
        m_ready <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_extremes();
        test_special_settings();
        test_random_phases();
        test_output_stall();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d pixel items over default, special and random lens settings;",
                 items_sent);
        $display("checked %0d result items, including a long output stall.", results_seen);
        if (mismatches == 0 && expected_coords.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d, result items missing: %0d",
                     mismatches, expected_coords.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d result items outstanding", expected_coords.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ fisheye_undistort_map_generator.f @@
rtl/core/fud_pkg.sv
rtl/core/fud_div.sv
rtl/core/fud_sqrt.sv
rtl/core/fud_rot.sv
rtl/core/fud_vec.sv
rtl/core/fisheye_undistort_map_generator.sv
sim/fisheye_undistort_map_generator_test.sv
